// File: sv/uibed_pkg.sv
// Shared types, command codes and the quadrature step table for the
// switch and rotary-encoder poll decoder. No dependencies.
package uibed_pkg;

  // Command codes carried on the result channel.
  localparam logic [2:0] CMD_NONE   = 3'd0;
  localparam logic [2:0] CMD_CANCEL = 3'd1;
  localparam logic [2:0] CMD_ENTER  = 3'd2;
  localparam logic [2:0] CMD_CCW    = 3'd3;
  localparam logic [2:0] CMD_CW     = 3'd4;
  localparam logic [2:0] CMD_UP     = 3'd5;
  localparam logic [2:0] CMD_DOWN   = 3'd6;

  // Switch bit positions in each sample.
  localparam int unsigned BIT_CANCEL = 0;
  localparam int unsigned BIT_UP     = 1;
  localparam int unsigned BIT_DOWN   = 2;
  localparam int unsigned BIT_ENTER  = 3;

  // Detent field of a table entry.
  localparam logic [1:0] DIR_NONE = 2'b00;
  localparam logic [1:0] DIR_CW   = 2'b01;
  localparam logic [1:0] DIR_CCW  = 2'b10;

  localparam logic [3:0] LEVEL_RELEASED = 4'hF;
  localparam logic [2:0] PHASE_START    = 3'd0;

  typedef struct packed {
    logic [3:0] switch_first;
    logic [3:0] switch_confirm;
    logic [1:0] encoder_pins;
  } uibed_item_t;

  typedef struct packed {
    logic [3:0] switch_level;
    logic [2:0] encoder_phase;
  } uibed_state_t;

  typedef struct packed {
    logic [1:0] dir;
    logic [2:0] next_row;
  } quad_entry_t;

  // Row is the previous phase, column the current pins. Rows 6 and 7 never
  // occur and are read as row 0.
  function automatic quad_entry_t quad_step(input logic [2:0] row, input logic [1:0] pins);
    quad_entry_t e;
    e = '{dir: DIR_NONE, next_row: 3'd0};
    unique case ({row, pins})
      5'b000_01: e.next_row = 3'd1;
      5'b000_10: e.next_row = 3'd4;
      5'b001_01: e.next_row = 3'd1;
      5'b001_11: e = '{dir: DIR_CW, next_row: 3'd2};
      5'b010_00: e.next_row = 3'd2;
      5'b010_01: e.next_row = 3'd5;
      5'b010_10: e.next_row = 3'd3;
      5'b010_11: e.next_row = 3'd2;
      5'b011_00: e = '{dir: DIR_CW, next_row: 3'd0};
      5'b011_01: e.next_row = 3'd2;
      5'b011_10: e.next_row = 3'd3;
      5'b011_11: e.next_row = 3'd2;
      5'b100_10: e.next_row = 3'd4;
      5'b100_11: e = '{dir: DIR_CCW, next_row: 3'd2};
      5'b101_00: e = '{dir: DIR_CCW, next_row: 3'd0};
      5'b101_01: e.next_row = 3'd5;
      5'b101_10: e.next_row = 3'd2;
      5'b101_11: e.next_row = 3'd2;
      5'b110_01, 5'b111_01: e.next_row = 3'd1;
      5'b110_10, 5'b111_10: e.next_row = 3'd4;
      default: e = '{dir: DIR_NONE, next_row: 3'd0};
    endcase
    return e;
  endfunction

endpackage

// File: sv/uibed_decode.sv
// Combinational decode of one poll item against the stored switch levels
// and encoder phase. Depends on uibed_pkg.
module uibed_decode import uibed_pkg::*; (
  input  uibed_item_t  item,
  input  uibed_state_t cur,
  output uibed_state_t nxt,
  output logic [2:0]   ui_command
);

  logic [3:0]  changed;
  logic [3:0]  pressed;
  quad_entry_t step;

  always_comb begin
    // A switch changes only when both samples disagree with its level.
    for (int i = 0; i < 4; i++) begin
      changed[i] = (item.switch_first[i] != cur.switch_level[i]) &&
                   (item.switch_confirm[i] != cur.switch_level[i]);
      pressed[i] = changed[i] && !item.switch_confirm[i];
    end
    step = quad_step(cur.encoder_phase, item.encoder_pins);
  end

  always_comb begin
    nxt        = cur;
    ui_command = CMD_NONE;
    if (changed[BIT_CANCEL]) nxt.switch_level[BIT_CANCEL] = item.switch_confirm[BIT_CANCEL];
    if (pressed[BIT_CANCEL]) begin
      ui_command = CMD_CANCEL;
    end else begin
      if (changed[BIT_ENTER]) nxt.switch_level[BIT_ENTER] = item.switch_confirm[BIT_ENTER];
      if (pressed[BIT_ENTER]) begin
        ui_command = CMD_ENTER;
      end else begin
        // Later checks are skipped once an earlier one fires.
        nxt.encoder_phase = step.next_row;
        if (step.dir != DIR_NONE) begin
          ui_command = (step.dir == DIR_CCW) ? CMD_CCW : CMD_CW;
        end else begin
          if (changed[BIT_UP]) nxt.switch_level[BIT_UP] = item.switch_confirm[BIT_UP];
          if (pressed[BIT_UP]) begin
            ui_command = CMD_UP;
          end else begin
            if (changed[BIT_DOWN]) begin
              nxt.switch_level[BIT_DOWN] = item.switch_confirm[BIT_DOWN];
            end
            if (pressed[BIT_DOWN]) ui_command = CMD_DOWN;
          end
        end
      end
    end
  end

endmodule

// File: sv/ui_button_and_encoder_decoder.sv
// Top level of the switch and rotary-encoder poll decoder: input register,
// decode stage and output register. Depends on uibed_pkg and uibed_decode.
//
//   channel | direction | payload
//   in_     | sink      | switch_first, switch_confirm, encoder_pins
//   out_    | source    | ui_command
//
// Every accepted poll request yields one command, through the input register and
// then the output register; one request is taken per cycle while out_ does not stall.
// Switch levels and encoder phase update as the request leaves the input
// register, so the next request sees them without a gap.
// Reset (rst_n low, synchronous) releases all switches, puts the encoder at
// phase 0 and empties both registers. A stall on out_tready holds the output stage and a held request.
module ui_button_and_encoder_decoder import uibed_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [3:0] switch_first, [7:4] switch_confirm, [9:8] encoder_pins, [15:10] zero
  input  logic [15:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [2:0] ui_command, [7:3] zero
  output logic [7:0]  out_tdata
);

  uibed_item_t  item_r;
  logic         item_valid_r;
  uibed_state_t state_r;
  uibed_state_t state_nxt;
  logic [2:0]   cmd_nxt;
  logic [2:0]   cmd_r;
  logic         out_valid_r;
  logic         advance;

  assign advance   = item_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !item_valid_r || advance;

  uibed_decode u_decode (
    .item       (item_r),
    .cur        (state_r),
    .nxt        (state_nxt),
    .ui_command (cmd_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r        <= 1'b0;
      out_valid_r         <= 1'b0;
      state_r.switch_level  <= LEVEL_RELEASED;
      state_r.encoder_phase <= PHASE_START;
    end else begin
      if (in_tready) item_valid_r <= in_tvalid;
      if (advance) begin
        out_valid_r <= 1'b1;
        state_r     <= state_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r.switch_first   <= in_tdata[3:0];
      item_r.switch_confirm <= in_tdata[7:4];
      item_r.encoder_pins   <= in_tdata[9:8];
    end
    if (advance) cmd_r <= cmd_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, cmd_r};

endmodule

// File: sv/uibed_checker.sv
// Port-level checks for ui_button_and_encoder_decoder, attached by bind.
// Depends on the top level's port list only.
module uibed_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [15:0] in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // A waiting request holds until it is taken.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid && $stable(in_tdata))
    else $error("request changed while waiting");

  // Only defined command codes appear, with zero padding.
  a_cmd_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[2:0] != 3'd7 && out_tdata[7:3] == 5'd0)
    else $error("undefined command code");

  // A sink that takes results never holds back requests.
  a_no_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("request stalled while output drains");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind ui_button_and_encoder_decoder uibed_checker u_uibed_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
